### rtl/joystick_thruster_mixer_assert.svh
// Assertion macros used by the joystick thruster mixer RTL.
`ifndef JOYSTICK_THRUSTER_MIXER_ASSERT_SVH
`define JOYSTICK_THRUSTER_MIXER_ASSERT_SVH

// Same-cycle implication, clocked on clk, quiet during reset.
`define JTM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, quiet during reset.
`define JTM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/jtm_pkg.sv
// Types, constants and the thruster scaling function of the joystick thruster mixer.
package jtm_pkg;

    typedef struct packed {
        logic signed [15:0] axis_sway;
        logic signed [15:0] axis_surge;
        logic signed [15:0] axis_yaw;
        logic signed [15:0] axis_level;
        logic signed [15:0] axis_tilt;
        logic [11:0]        button_bits;
    } sample_t;

    typedef struct packed {
        logic [10:0] thruster_a;
        logic [10:0] thruster_b;
        logic [10:0] thruster_c;
        logic [10:0] thruster_d;
        logic [10:0] thruster_e;
        logic [10:0] thruster_f;
        logic        arm_on;
        logic        piston_on;
        logic        lamp_on;
        logic        micro_active;
        logic        reversed;
    } result_t;

    typedef struct packed {
        logic reverse;
        logic front_en;
        logic back_en;
        logic micro;
    } modes_t;

    typedef struct packed {
        logic [8:0] turn;
        logic [8:0] surge;
        logic [8:0] sway;
        logic [8:0] heave;
    } gains_t;

    typedef struct packed {
        logic [10:0] a;
        logic [10:0] b;
        logic [10:0] c;
        logic [10:0] d;
        logic [10:0] e;
        logic [10:0] f;
    } thrust_t;

    localparam logic [2:0] CFG_TURN_GAIN   = 3'd0;
    localparam logic [2:0] CFG_SURGE_GAIN  = 3'd1;
    localparam logic [2:0] CFG_SWAY_GAIN   = 3'd2;
    localparam logic [2:0] CFG_HEAVE_GAIN  = 3'd3;
    localparam logic [2:0] CFG_LINE_FOLLOW = 3'd4;

    localparam logic [8:0]  GAIN_RESET = 9'd200;
    localparam logic [10:0] NEUTRAL    = 11'd1500;
    localparam logic [10:0] OUT_MIN    = 11'd1000;
    localparam logic [10:0] OUT_MAX    = 11'd2000;

    localparam logic signed [15:0] YAW_POS_LIMIT = 16'sd6554;
    localparam logic signed [15:0] YAW_NEG_LIMIT = -16'sd13108;

    localparam int BTN_ARM    = 0;
    localparam int BTN_DOWN   = 2;
    localparam int BTN_PISTON = 3;
    localparam int BTN_UP     = 4;
    localparam int BTN_LAMP   = 5;

    // Neutral plus the signed product scaled by 2^-15 (or 2^-16 for heave),
    // floored, then saturated to the pulse range; neutral when zero is set.
    function automatic logic [10:0] mix_value(
        input logic signed [27:0] prod,
        input logic               neg,
        input logic               zero,
        input logic               half
    );
        logic signed [28:0] term;
        logic signed [28:0] shifted;
        logic signed [28:0] sum;
        logic [10:0]        res;
        term    = neg ? -29'(prod) : 29'(prod);
        shifted = half ? (term >>> 16) : (term >>> 15);
        sum     = 29'(signed'({1'b0, NEUTRAL})) + shifted;
        if (zero)
        begin
            res = NEUTRAL;
        end
        else if (sum < 29'(signed'({1'b0, OUT_MIN})))
        begin
            res = OUT_MIN;
        end
        else if (sum > 29'(signed'({1'b0, OUT_MAX})))
        begin
            res = OUT_MAX;
        end
        else
        begin
            res = sum[10:0];
        end
        return res;
    endfunction

endpackage

### rtl/jtm_mixer.sv
// Combinational mixing of one joystick sample into six thruster pulse widths.
module jtm_mixer (
    input  jtm_pkg::sample_t sample,
    input  jtm_pkg::modes_t  modes,
    input  jtm_pkg::gains_t  gains,
    output jtm_pkg::thrust_t thrust
);

    logic               yaw_act;
    logic               surge_act;
    logic               sway_act;
    logic               h_none;
    logic [8:0]         h_gain;
    logic signed [15:0] h_axis;
    logic signed [27:0] h_prod;

    logic               tilt_act;
    logic               up_act;
    logic               down_act;
    logic               v_none;
    logic [8:0]         v_gain;
    logic signed [17:0] v_op;
    logic signed [27:0] v_prod;
    logic               v_neg_e;
    logic               v_neg_f;

    // Horizontal: yaw outside the dead band wins, then surge, then sway.
    always_comb
    begin
        yaw_act   = (sample.axis_yaw >= jtm_pkg::YAW_POS_LIMIT) ||
                    (sample.axis_yaw <= jtm_pkg::YAW_NEG_LIMIT);
        surge_act = !yaw_act && (sample.axis_surge != 16'sd0);
        sway_act  = !yaw_act && !surge_act && (sample.axis_sway != 16'sd0);
        h_none    = !yaw_act && !surge_act && !sway_act;
        if (yaw_act)
        begin
            h_gain = gains.turn;
            h_axis = sample.axis_yaw;
        end
        else if (surge_act)
        begin
            h_gain = gains.surge;
            h_axis = sample.axis_surge;
        end
        else
        begin
            h_gain = gains.sway;
            h_axis = sample.axis_sway;
        end
        h_prod = 28'(signed'({1'b0, h_gain})) * 28'(h_axis);
    end

    // Vertical: tilt wins, then up, then down; heave uses the level mapped to 0..65535.
    always_comb
    begin
        tilt_act = (sample.axis_tilt != 16'sd0);
        up_act   = !tilt_act && sample.button_bits[jtm_pkg::BTN_UP];
        down_act = !tilt_act && !up_act && sample.button_bits[jtm_pkg::BTN_DOWN];
        v_none   = !tilt_act && !up_act && !down_act;
        if (tilt_act)
        begin
            v_gain = gains.turn;
            v_op   = 18'(sample.axis_tilt);
        end
        else
        begin
            v_gain = gains.heave;
            v_op   = signed'({2'b00, ~sample.axis_level[15], sample.axis_level[14:0]});
        end
        v_prod = 28'(signed'({1'b0, v_gain})) * 28'(v_op);
        if (tilt_act)
        begin
            v_neg_e = !modes.reverse;
            v_neg_f = !modes.reverse;
        end
        else
        begin
            v_neg_e = down_act;
            v_neg_f = up_act;
        end
    end

    assign thrust.a = jtm_pkg::mix_value(h_prod, modes.reverse ^ (yaw_act || sway_act),
                                         h_none || !modes.front_en, 1'b0);
    assign thrust.b = jtm_pkg::mix_value(h_prod, modes.reverse,
                                         h_none || !modes.front_en, 1'b0);
    assign thrust.c = jtm_pkg::mix_value(h_prod, modes.reverse ^ yaw_act,
                                         h_none || !modes.back_en, 1'b0);
    assign thrust.d = jtm_pkg::mix_value(h_prod, modes.reverse ^ sway_act,
                                         h_none || !modes.back_en, 1'b0);
    assign thrust.e = jtm_pkg::mix_value(v_prod, v_neg_e, v_none, !tilt_act);
    assign thrust.f = jtm_pkg::mix_value(v_prod, v_neg_f, v_none, !tilt_act);

endmodule

### rtl/joystick_thruster_mixer.sv
// Joystick thruster mixer: the top level with sample register, mode state and result register.
// One sample is taken every cycle while sample_stall is low. It is registered in the sample
// register at the accepting edge, mixed in a single pass and then captured in the result
// register. The mix uses a 10x16 multiplier shared by the four horizontal thrusters and a
// 10x18 one for the vertical pair. A stalled result holds the sample register; once both
// are full the sample side stalls. Thruster values and modes live in the result and mode
// registers and start at neutral 1500 with front and back enabled, reverse and micro mode
// off.
`include "joystick_thruster_mixer_assert.svh"

module joystick_thruster_mixer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  jtm_pkg::sample_t  sample,
    output logic              result_valid,
    input  logic              result_stall,
    output jtm_pkg::result_t  result,
    input  logic              cfg_write,
    input  logic [2:0]        cfg_index,
    input  logic [8:0]        cfg_data
);

    logic              smp_vld_reg;
    jtm_pkg::sample_t  smp_reg;
    logic              res_vld_reg;
    logic              res_vld_next;
    jtm_pkg::result_t  res_reg;
    jtm_pkg::result_t  res_next;
    jtm_pkg::modes_t   modes_reg;
    jtm_pkg::modes_t   modes_next;
    logic [3:0]        prev_reg;
    logic [3:0]        rise;
    jtm_pkg::gains_t   gains_reg;
    logic              lf_reg;
    jtm_pkg::thrust_t  thrust;
    logic              advance;
    logic              fire;

    assign advance      = !res_vld_reg || !result_stall;
    assign fire         = smp_vld_reg && advance;
    assign sample_stall = smp_vld_reg && !advance;
    assign result_valid = res_vld_reg;
    assign result       = res_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg.turn  <= jtm_pkg::GAIN_RESET;
            gains_reg.surge <= jtm_pkg::GAIN_RESET;
            gains_reg.sway  <= jtm_pkg::GAIN_RESET;
            gains_reg.heave <= jtm_pkg::GAIN_RESET;
            lf_reg          <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                jtm_pkg::CFG_TURN_GAIN:   gains_reg.turn  <= cfg_data;
                jtm_pkg::CFG_SURGE_GAIN:  gains_reg.surge <= cfg_data;
                jtm_pkg::CFG_SWAY_GAIN:   gains_reg.sway  <= cfg_data;
                jtm_pkg::CFG_HEAVE_GAIN:  gains_reg.heave <= cfg_data;
                jtm_pkg::CFG_LINE_FOLLOW: lf_reg          <= cfg_data[0];
                default:                  ;
            endcase
        end
    end

    // Sample register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp_vld_reg <= 1'b0;
        end
        else if (!sample_stall)
        begin
            smp_vld_reg <= sample_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!sample_stall && sample_valid)
        begin
            smp_reg <= sample;
        end
    end

    // Toggle modes on rising edges of buttons 8 to 11.
    always_comb
    begin
        rise                = smp_reg.button_bits[11:8] & ~prev_reg;
        modes_next          = modes_reg;
        modes_next.front_en = modes_reg.front_en ^ rise[0];
        modes_next.micro    = modes_reg.micro ^ rise[1];
        modes_next.back_en  = modes_reg.back_en ^ rise[2];
        modes_next.reverse  = modes_reg.reverse ^ rise[3];
    end

    jtm_mixer u_mixer (
        .sample (smp_reg),
        .modes  (modes_next),
        .gains  (gains_reg),
        .thrust (thrust)
    );

    always_comb
    begin
        res_vld_next = advance ? smp_vld_reg : res_vld_reg;
        res_next     = res_reg;
        if (fire)
        begin
            res_next.arm_on       = smp_reg.button_bits[jtm_pkg::BTN_ARM];
            res_next.piston_on    = smp_reg.button_bits[jtm_pkg::BTN_PISTON];
            res_next.lamp_on      = smp_reg.button_bits[jtm_pkg::BTN_LAMP];
            res_next.micro_active = modes_next.micro;
            res_next.reversed     = modes_next.reverse;
            // Hold thruster values while line following.
            if (!lf_reg)
            begin
                res_next.thruster_a = thrust.a;
                res_next.thruster_b = thrust.b;
                res_next.thruster_c = thrust.c;
                res_next.thruster_d = thrust.d;
                res_next.thruster_e = thrust.e;
                res_next.thruster_f = thrust.f;
            end
        end
    end

    // Result register doubles as the thruster state, so it is reset to neutral.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg          <= 1'b0;
            res_reg.thruster_a   <= jtm_pkg::NEUTRAL;
            res_reg.thruster_b   <= jtm_pkg::NEUTRAL;
            res_reg.thruster_c   <= jtm_pkg::NEUTRAL;
            res_reg.thruster_d   <= jtm_pkg::NEUTRAL;
            res_reg.thruster_e   <= jtm_pkg::NEUTRAL;
            res_reg.thruster_f   <= jtm_pkg::NEUTRAL;
            res_reg.arm_on       <= 1'b0;
            res_reg.piston_on    <= 1'b0;
            res_reg.lamp_on      <= 1'b0;
            res_reg.micro_active <= 1'b0;
            res_reg.reversed     <= 1'b0;
            modes_reg.reverse    <= 1'b0;
            modes_reg.front_en   <= 1'b1;
            modes_reg.back_en    <= 1'b1;
            modes_reg.micro      <= 1'b0;
            prev_reg             <= 4'b0000;
        end
        else
        begin
            res_vld_reg <= res_vld_next;
            res_reg     <= res_next;
            if (fire)
            begin
                modes_reg <= modes_next;
                prev_reg  <= smp_reg.button_bits[11:8];
            end
        end
    end

    `JTM_ASSERT_NOW(a_stall_only_when_full, sample_stall, smp_vld_reg && res_vld_reg, "sample stalled with a free stage")
    `JTM_ASSERT_NEXT(a_fire_fills_result, fire, res_vld_reg, "mixed item lost before the result register")
    `JTM_ASSERT_NEXT(a_modes_move_on_fire, !fire, $stable(modes_reg) && $stable(prev_reg), "mode state changed without an item")
    `JTM_ASSERT_NEXT(a_line_follow_holds, fire && lf_reg, $stable(res_reg.thruster_a) && $stable(res_reg.thruster_e), "thrusters moved while line following")
    `JTM_ASSERT_NOW(a_thruster_range, 1'b1, (res_reg.thruster_b >= jtm_pkg::OUT_MIN) && (res_reg.thruster_b <= jtm_pkg::OUT_MAX) && (res_reg.thruster_f >= jtm_pkg::OUT_MIN) && (res_reg.thruster_f <= jtm_pkg::OUT_MAX), "thruster outside pulse range")

endmodule
